// File: sv/lbpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_pkg
// Shared types, constants and the log2 lookup table of the band peak meter.
// ----------------------------------------------------------------------------
package lbpm_pkg;

  localparam int unsigned BANDS      = 16;
  localparam int unsigned ROWS_DEF   = 16;
  localparam int unsigned BAND_W     = 4;
  localparam int unsigned ROWF_W     = 4;
  localparam int unsigned PEAK_W     = 8;
  localparam int unsigned HEIGHT_W   = 15;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned SLEW_W     = 12;
  localparam int unsigned LOG_W      = 19;
  localparam int unsigned IDX_W      = 9;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CMDQ_DEPTH = 4;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 10'd256;
  localparam logic [SLEW_W-1:0] SLEW_RST  = 12'd205;
  localparam logic [IDX_W-1:0]  BIN_LIMIT = 9'd255;

  // Lower bin edge of each band, band 0 in the lowest slot.
  localparam logic [BANDS-1:0][IDX_W-1:0] BIN_EDGE = {
    9'd187, 9'd137, 9'd101, 9'd74, 9'd54, 9'd40, 9'd28, 9'd20,
    9'd14,  9'd10,  9'd7,   9'd5,  9'd3,  9'd2,  9'd1,  9'd0
  };

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_FRAME  = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic {
    REG_GAIN = 1'b0,
    REG_SLEW = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_PEAK  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [BAND_W-1:0]   band;
    logic [PEAK_W-1:0]   peak;
    logic [ROWF_W-1:0]   row;
  } cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [SLEW_W-1:0] slew;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [ROWF_W-1:0]   row;
    logic [BAND_W-1:0]   column;
    logic [HEIGHT_W-1:0] height;
    logic                last;
  } res_t;

  // log2(p) in Q3.16 by repeated squaring of a Q1.30 mantissa; evaluated
  // at elaboration only.
  function automatic logic [255:0][LOG_W-1:0] build_log2_tbl();
    logic [255:0][LOG_W-1:0] tbl;
    logic [63:0]             m;
    logic [LOG_W-1:0]        acc;
    int unsigned             n;
    tbl = '0;
    for (int p = 1; p < 256; p++) begin
      n = 0;
      while ((p >> (n + 1)) != 0) begin
        n++;
      end
      m   = 64'(p) << (30 - n);
      acc = LOG_W'(n) << 16;
      for (int k = 15; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= 64'h0000_0000_8000_0000) begin
          m      = m >> 1;
          acc[k] = 1'b1;
        end
      end
      tbl[p] = acc;
    end
    return tbl;
  endfunction

  localparam logic [255:0][LOG_W-1:0] LOG2_TBL = build_log2_tbl();

endpackage

// File: sv/lbpm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_front
// Accept input items, track the bin index, map samples to bands and turn
// each kept item into a command for the execution side.
// ----------------------------------------------------------------------------
module lbpm_front #(
  parameter int unsigned ROWS = lbpm_pkg::ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      in_func_i,
  input  logic [lbpm_pkg::SAMPLE_W-1:0]   in_sample_i,
  input  logic [lbpm_pkg::ROWF_W-1:0]     in_row_i,
  output logic                            cmd_valid_o,
  output lbpm_pkg::cmd_t                  cmd_o,
  input  logic                            cmd_ready_i
);
  import lbpm_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BAND_W-1:0] band;
  logic              keep;
  logic              fire;

  assign in_ready_o  = cmd_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign cmd_valid_o = in_valid_i && keep;

  always_comb begin
    band = '0;
    for (int i = 1; i < BANDS; i++) begin
      if (idx_q >= BIN_EDGE[i]) begin
        band = BAND_W'(i);
      end
    end
  end

  always_comb begin
    keep       = 1'b0;
    idx_d      = idx_q;
    cmd_o.op   = CMD_PEAK;
    cmd_o.band = band;
    cmd_o.peak = in_sample_i[SAMPLE_W-2:SAMPLE_W-1-PEAK_W];
    cmd_o.row  = in_row_i;
    unique case (func_e'(in_func_i))
      FUNC_SAMPLE: begin
        if (idx_q != '1) begin
          idx_d = idx_q + 1'b1;
        end
        // drop late bins and samples that are zero or negative
        keep = (idx_q < BIN_LIMIT) && !in_sample_i[SAMPLE_W-1] && (in_sample_i != '0);
      end
      FUNC_FRAME: begin
        cmd_o.op = CMD_FRAME;
        idx_d    = '0;
        keep     = 1'b1;
      end
      FUNC_TICK: begin
        cmd_o.op = CMD_TICK;
        keep     = (32'(in_row_i) < ROWS);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: sv/lbpm_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_cmdq
// Short command queue between the classifying and the executing side.
// ----------------------------------------------------------------------------
module lbpm_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  lbpm_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output lbpm_pkg::cmd_t  pop_data_o
);
  import lbpm_pkg::*;

  localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slot_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(CMDQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CMDQ_DEPTH))
    else $error("command queue count beyond depth");

endmodule

// File: sv/lbpm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpm_back
// Execute commands: update band peaks, convert peaks to heights and push
// them into the history, and slew shown heights toward history targets.
// ----------------------------------------------------------------------------
module lbpm_back #(
  parameter int unsigned ROWS = lbpm_pkg::ROWS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lbpm_pkg::cfg_t  cfg_i,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  lbpm_pkg::cmd_t  cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lbpm_pkg::res_t  out_o
);
  import lbpm_pkg::*;

  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = ROW_W + BAND_W;
  localparam int unsigned DEPTH  = ROWS * BANDS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [BAND_W-1:0]   cell_q;
  cmd_op_e             op_q;
  logic [ROWF_W-1:0]   row_q;
  logic [ROW_W-1:0]    head_q, phys_q;
  logic [PEAK_W-1:0]   peak_q [BANDS];
  logic [ROWS-1:0]     hist_vld_q, shown_vld_q;
  logic                out_vld_q;
  res_t                out_q;

  logic [LOG_W-1:0]    log_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [HEIGHT_W-1:0] hist_rd_q, shown_rd_q;
  logic                hvld_rd_q, svld_rd_q;

  logic [HEIGHT_W-1:0] hist_mem  [DEPTH];
  logic [HEIGHT_W-1:0] shown_mem [DEPTH];

  logic                pop, emit_go, last_cell;
  logic [BAND_W-1:0]   peak_idx;
  logic [PEAK_W-1:0]   peak_rd;
  logic [ROW_W:0]      phys_sum;
  logic [ROW_W-1:0]    phys_next, row_idx, cmd_row_idx;
  logic [ADDR_W-1:0]   hist_addr, shown_addr;
  logic [29:0]         prod;
  logic [HEIGHT_W-1:0] cur, tgt, gap, step, slewed;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign emit_go     = (state_q == ST_EMIT) && (!out_vld_q || out_ready_i);
  assign last_cell   = (cell_q == BAND_W'(BANDS - 1));
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // one read port on the peak registers, shared by update and frame end
  assign peak_idx = (state_q == ST_IDLE) ? cmd_i.band : cell_q;
  assign peak_rd  = peak_q[peak_idx];

  // physical slot of a logical row; head and row are both below ROWS
  assign cmd_row_idx = ROW_W'(cmd_i.row);
  assign phys_sum    = {1'b0, head_q} + {1'b0, cmd_row_idx};
  assign phys_next   = (phys_sum >= (ROW_W + 1)'(ROWS)) ?
                       ROW_W'(phys_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(phys_sum);
  assign row_idx     = ROW_W'(row_q);

  assign hist_addr  = (op_q == CMD_FRAME) ? {head_q, cell_q} : {phys_q, cell_q};
  assign shown_addr = {row_idx, cell_q};

  // gain * log2 / 8, rounded to Q3.12
  assign prod = 30'(cfg_i.gain) * 30'(log_q) + 30'(1 << 14);

  always_comb begin
    cur    = svld_rd_q ? shown_rd_q : '0;
    tgt    = hvld_rd_q ? hist_rd_q : '0;
    gap    = (cur > tgt) ? cur - tgt : tgt - cur;
    step   = HEIGHT_W'(cfg_i.slew);
    slewed = cur;
    if (gap > step) begin
      slewed = (cur < tgt) ? cur + step : cur - step;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && (cmd_i.op == CMD_FRAME || cmd_i.op == CMD_TICK)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_d = last_cell ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cell_q      <= '0;
      op_q        <= CMD_PEAK;
      row_q       <= '0;
      head_q      <= '0;
      phys_q      <= '0;
      hist_vld_q  <= '0;
      shown_vld_q <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < BANDS; i++) begin
        peak_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop) begin
        op_q   <= cmd_i.op;
        row_q  <= cmd_i.row;
        cell_q <= '0;
        case (cmd_i.op)
          CMD_PEAK: begin
            if (cmd_i.peak > peak_rd) begin
              peak_q[cmd_i.band] <= cmd_i.peak;
            end
          end
          CMD_FRAME: begin
            head_q <= (head_q == '0) ? ROW_W'(ROWS - 1) : head_q - 1'b1;
          end
          CMD_TICK: begin
            phys_q <= phys_next;
          end
          default: ;
        endcase
      end
      // clear each peak as it is converted
      if (state_q == ST_READ && op_q == CMD_FRAME) begin
        peak_q[cell_q] <= '0;
      end
      if (emit_go) begin
        cell_q <= cell_q + 1'b1;
        if (last_cell) begin
          if (op_q == CMD_FRAME) begin
            hist_vld_q[head_q] <= 1'b1;
          end else begin
            shown_vld_q[row_idx] <= 1'b1;
          end
        end
      end
      if (emit_go) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      log_q      <= LOG2_TBL[peak_rd];
      hist_rd_q  <= hist_mem[hist_addr];
      shown_rd_q <= shown_mem[shown_addr];
      hvld_rd_q  <= hist_vld_q[phys_q];
      svld_rd_q  <= shown_vld_q[row_idx];
    end
    if (state_q == ST_CALC) begin
      height_q <= (op_q == CMD_FRAME) ? prod[29:15] : slewed;
    end
    if (emit_go) begin
      if (op_q == CMD_FRAME) begin
        hist_mem[hist_addr] <= height_q;
      end else begin
        shown_mem[shown_addr] <= height_q;
      end
      out_q.kind   <= (op_q == CMD_TICK);
      out_q.row    <= (op_q == CMD_TICK) ? row_q : '0;
      out_q.column <= cell_q;
      out_q.height <= height_q;
      out_q.last   <= last_cell;
    end
  end

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.last == (out_q.column == BAND_W'(BANDS - 1))))
    else $error("last flag does not match final column");

  a_new_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.kind) |-> (out_q.row == '0))
    else $error("new band value reported on a row other than the newest");

  a_rose_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside the emit step");

endmodule

// File: sv/log_band_peak_bar_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_band_peak_bar_meter_core
// Band peak meter with log height conversion, row history and slew-limited
// shown heights.
// ----------------------------------------------------------------------------
// Feed audio samples of a frame on the input stream (tuser 0), close the
// frame with tuser 1, and request a smoothed row with tuser 2 and the row
// number in tdata. Samples only update band peaks and give no result. A frame
// end emits sixteen new band heights (tuser 0 on the output), a row tick emits
// the sixteen shown heights of that row (tuser 1); tlast marks the sixteenth.
// Ticks for rows at or beyond ROWS and the unused code are dropped. The input
// side classifies items and queues them in a four-entry command queue, so it
// keeps taking items while results drain. A sample command only updates a
// band peak; a frame end or row tick runs read, compute and emit for each
// band in turn on the execution side, over the history and shown-height
// memories, and waits out any output stall; no new command is taken until
// its last band is emitted. History and shown heights read as zero until
// their row has been written; per-row valid bits replace any clearing pass,
// so the block is ready right after reset. Write gain (address 0, unsigned
// Q2.8) and slew step (address 4, Q3.12) only while the block is idle.
// ----------------------------------------------------------------------------
module log_band_peak_bar_meter_core #(
  parameter int unsigned ROWS = lbpm_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] sample, [19:16] row, rest zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] out_row, [7:4] column, [22:8] height
  output logic [0:0]  m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lbpm_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic [SLEW_W-1:0] slew_q;
  cfg_t              cfg;
  logic              cfg_wr;

  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;
  logic              q_valid, q_ready;
  cmd_t              q_cmd;
  res_t              res;

  // Register port: zero wait states, register selected by address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      slew_q <= SLEW_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
        REG_SLEW: slew_q <= pwdata[SLEW_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[2]))
      REG_GAIN: prdata = 32'(gain_q);
      REG_SLEW: prdata = 32'(slew_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg.gain = gain_q;
  assign cfg.slew = slew_q;

  // Classify incoming items into commands.
  lbpm_front #(
    .ROWS (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_sample_i (s_axis_tdata[15:0]),
    .in_row_i    (s_axis_tdata[19:16]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Decouple classification from execution.
  lbpm_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // Execute commands and drive the registered result.
  lbpm_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign m_axis_tdata = {1'b0, res.height, res.column, res.row};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
